// ----- sv/swa_pkg.sv -----
// shared constants and types for the sliding window average core
package swa_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 9;
  localparam int SCALE      = 10;

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int LCMP_W = (LEN_W > CNT_W) ? LEN_W : CNT_W;
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int MAG_W  = SUM_W - 1;
  localparam int DVD_W  = MAG_W + 5;
  localparam int Q_W    = SAMPLE_W + 3;
  localparam int AVG_W  = 20;
  localparam int DIV_W  = CNT_W + 1;
  localparam int REM_W  = (DVD_W > DIV_W + Q_W) ? DVD_W : DIV_W + Q_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        len;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qpush_t;

  typedef struct packed {
    logic             neg;
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] dvs;
    logic [Q_W-1:0]   quo;
  } div_t;

endpackage

// ----- sv/swa_front.sv -----
// front end: window bookkeeping, delay line and running sum
module swa_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [swa_pkg::LEN_W-1:0]            cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [swa_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_start_sequence,
  input  logic [swa_pkg::QCNT_W-1:0]           q_count,
  output swa_pkg::qpush_t                      push
);

  localparam int CNT_W    = swa_pkg::CNT_W;
  localparam int PTR_W    = swa_pkg::PTR_W;
  localparam int SUM_W    = swa_pkg::SUM_W;
  localparam int SAMPLE_W = swa_pkg::SAMPLE_W;
  localparam int LCMP_W   = swa_pkg::LCMP_W;
  localparam int QCNT_W   = swa_pkg::QCNT_W;

  logic [swa_pkg::LEN_W-1:0] len_cfg_r;
  logic [CNT_W-1:0]          eff_len;
  logic [CNT_W-1:0]          fill_r;
  logic [CNT_W-1:0]          fill_base;
  logic [CNT_W-1:0]          fill_nxt;
  logic [PTR_W-1:0]          wp_r;
  logic [PTR_W-1:0]          wp_nxt;
  logic [PTR_W-1:0]          old_addr;
  logic [CNT_W:0]            back_dist;
  logic                      sub_c;
  logic                      prod_c;
  logic                      accept;
  logic [QCNT_W:0]           occ;

  logic signed [SAMPLE_W-1:0] mem [swa_pkg::MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] rd_r;

  logic                       s1_valid_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic                       s1_sub_r;
  logic                       s1_clear_r;
  logic                       s1_prod_r;
  logic [CNT_W-1:0]           s1_len_r;

  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] sum_base;
  logic signed [SUM_W-1:0] sub_val;

  always_comb begin
    if (len_cfg_r == '0) begin
      eff_len = CNT_W'(1);
    end else if (LCMP_W'(len_cfg_r) > LCMP_W'(swa_pkg::MAX_WINDOW)) begin
      eff_len = CNT_W'(swa_pkg::MAX_WINDOW);
    end else begin
      eff_len = CNT_W'(len_cfg_r);
    end
  end

  // room in the queue for this item and the one still in the sum stage
  assign occ      = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid_r & s1_prod_r);
  assign in_ready = (occ < (QCNT_W+1)'(swa_pkg::QDEPTH));
  assign accept   = in_valid & in_ready;

  always_comb begin
    fill_base = in_start_sequence ? '0 : fill_r;
    sub_c     = (fill_base >= eff_len);
    fill_nxt  = sub_c ? eff_len : fill_base + CNT_W'(1);
    prod_c    = (fill_nxt >= eff_len);
    wp_nxt    = (wp_r == PTR_W'(swa_pkg::MAX_WINDOW - 1)) ? '0 : wp_r + PTR_W'(1);
    back_dist = (CNT_W+1)'(wp_r) - (CNT_W+1)'(eff_len);
    if (CNT_W'(wp_r) >= eff_len) begin
      old_addr = PTR_W'(back_dist);
    end else begin
      old_addr = PTR_W'(back_dist + (CNT_W+1)'(swa_pkg::MAX_WINDOW));
    end
  end

  // delay line, read before write at the same address
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wp_r] <= in_sample;
      rd_r      <= mem[old_addr];
    end
  end

  always_comb begin
    sum_base = s1_clear_r ? '0 : sum_r;
    sub_val  = s1_sub_r ? SUM_W'(rd_r) : '0;
    sum_nxt  = sum_base - sub_val + SUM_W'(s1_sample_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r  <= swa_pkg::LEN_W'(1);
      fill_r     <= '0;
      wp_r       <= '0;
      s1_valid_r <= 1'b0;
      sum_r      <= '0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        fill_r <= fill_nxt;
        wp_r   <= wp_nxt;
      end
      if (s1_valid_r) begin
        sum_r <= sum_nxt;
      end
      if (cfg_wr_en) begin
        len_cfg_r <= cfg_wr_data;
        fill_r    <= '0;
        sum_r     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r <= in_sample;
      s1_sub_r    <= sub_c;
      s1_clear_r  <= in_start_sequence;
      s1_prod_r   <= prod_c;
      s1_len_r    <= eff_len;
    end
  end

  assign push.valid   = s1_valid_r & s1_prod_r;
  assign push.ent.sum = sum_nxt;
  assign push.ent.len = s1_len_r;

endmodule

// ----- sv/swa_fifo.sv -----
// short queue between the front end and the divider pipeline
module swa_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  swa_pkg::qpush_t            push,
  input  logic                       pop,
  output logic [swa_pkg::QCNT_W-1:0] count,
  output swa_pkg::qent_t             head
);

  localparam int QPTR_W = swa_pkg::QPTR_W;
  localparam int QCNT_W = swa_pkg::QCNT_W;

  swa_pkg::qent_t    mem [swa_pkg::QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  always_comb begin
    case ({push.valid, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(swa_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(swa_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr_r] <= push.ent;
    end
  end

  assign count = count_r;
  assign head  = mem[rd_ptr_r];

endmodule

// ----- sv/swa_back.sv -----
// back end: pipelined rounding divider and output register
module swa_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  swa_pkg::qent_t                      head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [swa_pkg::AVG_W-1:0]    out_average_tenths
);

  localparam int Q_W   = swa_pkg::Q_W;
  localparam int REM_W = swa_pkg::REM_W;
  localparam int SUM_W = swa_pkg::SUM_W;
  localparam int MAG_W = swa_pkg::MAG_W;
  localparam int AVG_W = swa_pkg::AVG_W;

  logic                    adv;
  logic                    st_valid_r [Q_W+1];
  swa_pkg::div_t           st_r       [Q_W+1];
  swa_pkg::div_t           st0_nxt;
  logic [SUM_W-1:0]        abs_sum;
  logic [MAG_W-1:0]        mag;
  logic                    out_valid_r;
  logic signed [AVG_W-1:0] out_avg_r;
  logic signed [AVG_W-1:0] quo_ext;

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && q_valid;

  // dividend is mag*20 + len over 2*len, giving half-away rounding of mag*10/len
  always_comb begin
    abs_sum     = head.sum[SUM_W-1] ? SUM_W'(-head.sum) : SUM_W'(head.sum);
    mag         = MAG_W'(abs_sum);
    st0_nxt.neg = head.sum[SUM_W-1];
    st0_nxt.rem = REM_W'(mag) * REM_W'(2 * swa_pkg::SCALE) + REM_W'(head.len);
    st0_nxt.dvs = REM_W'({head.len, 1'b0});
    st0_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r[0] <= 1'b0;
    end else if (adv) begin
      st_valid_r[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      st_r[0] <= st0_nxt;
    end
  end

  for (genvar i = 1; i <= Q_W; i++) begin : g_div
    localparam int BIT = Q_W - i;
    swa_pkg::div_t    nxt;
    logic [REM_W-1:0] trial;

    always_comb begin
      nxt   = st_r[i-1];
      trial = st_r[i-1].dvs << BIT;
      if (st_r[i-1].rem >= trial) begin
        nxt.rem      = st_r[i-1].rem - trial;
        nxt.quo[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_valid_r[i] <= 1'b0;
      end else if (adv) begin
        st_valid_r[i] <= st_valid_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[i] <= nxt;
      end
    end
  end

  assign quo_ext = AVG_W'(st_r[Q_W].quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= st_valid_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_avg_r <= st_r[Q_W].neg ? -quo_ext : quo_ext;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_average_tenths = out_avg_r;

endmodule

// ----- sv/sliding_window_average_core.sv -----
// top level of the sliding window average core
//
// Input transactions (in_valid/in_ready) carry one signed sample and a
// start-of-sequence flag. Once window_length samples have been taken since
// reset, the last start flag or the last configuration write, every sample
// gives one output transaction (out_valid/out_ready): the window mean in
// tenths, rounded half away from zero. Earlier samples give no output.
// cfg_wr_en with cfg_wr_data sets the window length (0 acts as 1, values
// above 256 act as 256) and starts a fresh window; write only when idle.
// Throughput is one sample per cycle while out_ready is held high. An
// accepted sample passes the delay line read and running sum, the queue
// into the setup stage, 19 divider stages (one quotient bit each) and the
// output register. A stalled receiver freezes the divider pipeline;
// the four-entry queue then fills and in_ready drops, with no transaction lost.
// Reset clears the window length to 1, the fill count, write pointer, sum
// and all valid bits; the delay line needs no clearing since only entries
// written in the current window are read.
module sliding_window_average_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [swa_pkg::LEN_W-1:0]           cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [swa_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_start_sequence,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [swa_pkg::AVG_W-1:0]    out_average_tenths
);

  swa_pkg::qpush_t             push;
  logic [swa_pkg::QCNT_W-1:0]  q_count;
  swa_pkg::qent_t              head;
  logic                        pop;

  swa_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_start_sequence (in_start_sequence),
    .q_count           (q_count),
    .push              (push)
  );

  swa_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .count (q_count),
    .head  (head)
  );

  swa_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_count != '0),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_average_tenths (out_average_tenths)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= swa_pkg::QCNT_W'(swa_pkg::QDEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> q_count < swa_pkg::QCNT_W'(swa_pkg::QDEPTH))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_count != '0)
    else $error("pop from empty queue");

  a_stall_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !pop)
    else $error("queue popped while output stalled");

endmodule

// ----- tb/tb_sliding_window_average_core.sv -----
// testbench for sliding_window_average_core: directed and random samples checked against a window-mean predictor
`timescale 1ns / 1ps

module tb_sliding_window_average_core;

  localparam int MAX_WINDOW = swa_pkg::MAX_WINDOW;
  localparam int SAMPLE_W   = swa_pkg::SAMPLE_W;
  localparam int LEN_W      = swa_pkg::LEN_W;
  localparam int PTR_W      = swa_pkg::PTR_W;
  localparam int AVG_W      = swa_pkg::AVG_W;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start;
  } sample_txn_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [LEN_W-1:0]           cfg_wr_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_start_sequence;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [AVG_W-1:0]    out_average_tenths;

  sample_txn_t             samples_pending[$];
  sample_txn_t             next_txn;
  logic signed [AVG_W-1:0] tenths_due[$];
  logic signed [AVG_W-1:0] want_tenths;

  logic signed [SAMPLE_W-1:0] hist [MAX_WINDOW];
  longint                     win_sum;
  int unsigned                win_fill;
  logic [PTR_W-1:0]           wr_ptr;
  logic [LEN_W-1:0]           win_len;

  int unsigned queued;
  int unsigned taken;
  int unsigned random_base;
  int unsigned fails;
  bit          steady;

  sliding_window_average_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .in_start_sequence  (in_start_sequence),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_average_tenths (out_average_tenths)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned eff_len(input logic [LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WINDOW) return MAX_WINDOW;
    return v;
  endfunction

  function automatic logic signed [AVG_W-1:0] mean_tenths(input longint s, input int unsigned n);
    longint mag;
    longint q;
    mag = (s < 0) ? -s : s;
    q = (mag * 20 + longint'(n)) / (longint'(n) * 2);
    return (s < 0) ? AVG_W'(-q) : AVG_W'(q);
  endfunction

  task automatic advance_window(input logic signed [SAMPLE_W-1:0] s, input logic start);
    int unsigned      n;
    logic [PTR_W-1:0] old;
    n = eff_len(win_len);
    if (start) begin
      win_fill = 0;
      win_sum  = 0;
    end
    if (win_fill >= n) begin
      old = wr_ptr - PTR_W'(n);
      win_sum -= longint'(hist[old]);
      win_fill = n;
    end else begin
      win_fill++;
    end
    hist[wr_ptr] = s;
    win_sum += longint'(s);
    wr_ptr++;
    if (win_fill >= n) tenths_due.push_back(mean_tenths(win_sum, n));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'sh7fff;
    if (r < 20) return 16'sh8000;
    if (r < 30) return SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
    return SAMPLE_W'($urandom);
  endfunction

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic start);
    samples_pending.push_back('{s, start});
    queued++;
  endtask

  task automatic drain();
    do @(posedge clk); while (taken != queued || tenths_due.size() != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_window(input logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_len  = v;
    win_fill = 0;
    win_sum  = 0;
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] len_cfg, input int unsigned count);
    drain();
    set_window(len_cfg);
    for (int unsigned i = 0; i < count; i++) begin
      push_sample(rand_sample(), (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) < 4));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_window(in_sample, in_start_sequence);
        taken++;
      end
      if (!in_valid || in_ready) begin
        if (samples_pending.size() != 0 && (steady || $urandom_range(0, 99) >= 20)) begin
          next_txn = samples_pending.pop_front();
          in_valid          <= 1'b1;
          in_sample         <= next_txn.sample;
          in_start_sequence <= next_txn.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tenths_due.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected transaction: average_tenths %0d", out_average_tenths);
        end else begin
          want_tenths = tenths_due.pop_front();
          if (out_average_tenths !== want_tenths) begin
            fails++;
            if (fails <= 10)
              $display("average_tenths mismatch at %0t: expected %0d, got %0d",
                       $time, want_tenths, out_average_tenths);
          end
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= 20);
    end
  end

  initial begin
    #5_000_000;
    $display("[sliding_window_average_core] ERROR");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned len;
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_valid          = 1'b0;
    in_sample         = '0;
    in_start_sequence = 1'b0;
    out_ready         = 1'b0;
    steady            = 1'b0;
    queued            = 0;
    taken             = 0;
    fails             = 0;
    foreach (hist[i]) hist[i] = '0;
    win_sum  = 0;
    win_fill = 0;
    wr_ptr   = '0;
    win_len  = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // zero length acts as one, sample extremes
    drain();
    set_window(9'd0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd1, 1'b1);

    // output extremes and a restart inside a short window
    drain();
    set_window(9'd2);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sd1, 1'b1);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd0, 1'b0);

    // rounding of halves away from zero
    drain();
    set_window(9'd4);
    push_sample(16'sd1, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(-16'sd1, 1'b1);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd0, 1'b0);

    random_base = queued;
    run_phase(9'd511, MAX_WINDOW + 30);
    run_phase(9'd257, 20);
    drain();
    steady = 1'b1;
    run_phase(9'd3, 150);
    drain();
    steady = 1'b0;
    run_phase(9'd256, MAX_WINDOW + 10);
    while (queued - random_base < 900) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 16);
      else if (r < 90) len = $urandom_range(17, 64);
      else len = $urandom_range(0, 1);
      run_phase(LEN_W'(len), eff_len(LEN_W'(len)) + $urandom_range(10, 80));
    end
    drain();

    if (fails == 0) begin
      $display("[sliding_window_average_core] OK");
    end else begin
      $display("[sliding_window_average_core] ERROR");
    end
    $finish;
  end

endmodule
